// ===== hdl/step_position_move_controller_defines.svh =====
// Assertion macros for the step position move controller checker.
// Each macro expects the clock clk and the active-low reset rst_n in scope.
`ifndef STEP_POSITION_MOVE_CONTROLLER_DEFINES_SVH
`define STEP_POSITION_MOVE_CONTROLLER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SPMC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmc: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SPMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmc: next-cycle check failed");

`endif

// ===== hdl/spmc_pkg.sv =====
package spmc_pkg;

    localparam int POSITION_BITS = 16;
    localparam int CFG_BITS      = 16;
    localparam int FIELD_BITS    = 16;
    localparam int CMP_BITS      = (POSITION_BITS > CFG_BITS) ? POSITION_BITS : CFG_BITS;

    localparam int HOME_RESET_POS   = 1000;
    localparam int RESET_MAX_VALUE  = HOME_RESET_POS * 2;
    localparam int RESET_PPU_VALUE  = 400;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [CFG_BITS-1:0]      cfg_word_t;
    typedef logic [CMP_BITS-1:0]      cmp_t;
    typedef logic [FIELD_BITS-1:0]    field_t;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_MOVE = 2'd1,
        OP_TICK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SAME   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_NOINIT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_HOME = 2'd0,
        CFG_MAX  = 2'd1,
        CFG_PPU  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        cfg_word_t home_location;
        cfg_word_t max_location;
        cfg_word_t pulses_per_unit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        field_t     target_location;
    } item_t;

endpackage

// ===== hdl/step_position_move_controller.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   opcode, target_location
// out       output     out_valid / out_stall status, running, direction, position
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; its result is registered.
// The input register feeds one pass of compare and increment logic into the result register.
// Reset leaves the axis disabled at position 1000 with the default register values.
// A stalled result holds the input register, so in_stall follows out_stall combinationally.
// Configuration writes are always ready and are registered.
module step_position_move_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] target_location,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        running,
    output logic        direction,
    output logic [15:0] position,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    spmc_pkg::cfg_t  cfg;
    spmc_pkg::item_t item;
    logic            item_valid;
    logic            advance;

    spmc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spmc_in_stage u_in (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .target_location (target_location),
        .advance         (advance),
        .item_valid      (item_valid),
        .item            (item)
    );

    spmc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .running    (running),
        .direction  (direction),
        .position   (position)
    );

endmodule

// ===== hdl/spmc_cfg_regs.sv =====
module spmc_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  spmc_pkg::cfg_word_t    cfg_data,
    output spmc_pkg::cfg_t         cfg
);

    spmc_pkg::cfg_t cfg_reg;
    spmc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spmc_pkg::CFG_HOME: cfg_next.home_location   = cfg_data;
                spmc_pkg::CFG_MAX:  cfg_next.max_location    = cfg_data;
                spmc_pkg::CFG_PPU:  cfg_next.pulses_per_unit = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_location   <= spmc_pkg::CFG_BITS'(spmc_pkg::HOME_RESET_POS);
            cfg_reg.max_location    <= spmc_pkg::CFG_BITS'(spmc_pkg::RESET_MAX_VALUE);
            cfg_reg.pulses_per_unit <= spmc_pkg::CFG_BITS'(spmc_pkg::RESET_PPU_VALUE);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/spmc_in_stage.sv =====
module spmc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  spmc_pkg::field_t    target_location,
    input  logic                advance,
    output logic                item_valid,
    output spmc_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    spmc_pkg::item_t item_reg;
    spmc_pkg::item_t item_next;
    logic            accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next                = 1'b1;
            item_next.opcode          = opcode;
            item_next.target_location = target_location;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/spmc_core.sv =====
module spmc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  spmc_pkg::item_t     item,
    input  spmc_pkg::cfg_t      cfg,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic                running,
    output logic                direction,
    output spmc_pkg::field_t    position
);

    typedef enum logic [1:0] {
        RS_IDLE     = 2'd0,
        RS_MOVING   = 2'd1,
        RS_DISABLED = 2'd2
    } run_state_t;

    run_state_t         state_reg;
    run_state_t         state_next;
    spmc_pkg::pos_t     position_reg;
    spmc_pkg::pos_t     position_next;
    spmc_pkg::pos_t     destination_reg;
    spmc_pkg::pos_t     destination_next;
    logic               direction_reg;
    logic               direction_next;
    spmc_pkg::cfg_word_t counter_reg;
    spmc_pkg::cfg_word_t counter_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               running_reg;
    logic               direction_out_reg;
    spmc_pkg::field_t   position_out_reg;

    logic               fire;
    spmc_pkg::pos_t     target_pos;
    spmc_pkg::pos_t     home_pos;
    spmc_pkg::pos_t     step_pos;
    logic               arrived;

    assign advance    = !out_valid_reg || !out_stall;
    assign fire       = item_valid && advance;
    assign target_pos = spmc_pkg::pos_t'(item.target_location);
    assign home_pos   = spmc_pkg::pos_t'(cfg.home_location);
    assign step_pos   = direction_reg ? (position_reg + 1'b1) : (position_reg - 1'b1);
    assign arrived    = direction_reg ? (step_pos >= destination_reg)
                                      : (step_pos <= destination_reg);

    always_comb
    begin
        state_next       = state_reg;
        position_next    = position_reg;
        destination_next = destination_reg;
        direction_next   = direction_reg;
        counter_next     = counter_reg;
        status_next      = spmc_pkg::ST_OK;
        out_valid_next   = advance ? item_valid : out_valid_reg;
        if (fire)
        begin
            case (item.opcode)
                spmc_pkg::OP_INIT:
                begin
                    position_next    = home_pos;
                    destination_next = home_pos;
                    direction_next   = 1'b0;
                    state_next       = RS_IDLE;
                end
                spmc_pkg::OP_MOVE:
                begin
                    if (state_reg == RS_DISABLED)
                    begin
                        status_next = spmc_pkg::ST_NOINIT;
                    end
                    else if (target_pos == position_reg)
                    begin
                        status_next = spmc_pkg::ST_SAME;
                    end
                    else if (spmc_pkg::cmp_t'(target_pos) > spmc_pkg::cmp_t'(cfg.max_location))
                    begin
                        status_next = spmc_pkg::ST_RANGE;
                    end
                    else
                    begin
                        destination_next = target_pos;
                        direction_next   = target_pos > position_reg;
                        if (state_reg == RS_IDLE)
                        begin
                            state_next = RS_MOVING;
                        end
                    end
                end
                spmc_pkg::OP_TICK:
                begin
                    if (state_reg == RS_MOVING)
                    begin
                        if (counter_reg > cfg.pulses_per_unit)
                        begin
                            position_next = step_pos;
                            counter_next  = '0;
                            if (arrived)
                            begin
                                state_next = RS_IDLE;
                            end
                        end
                        else
                        begin
                            counter_next = counter_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= RS_DISABLED;
            position_reg      <= spmc_pkg::POSITION_BITS'(spmc_pkg::HOME_RESET_POS);
            destination_reg   <= '0;
            direction_reg     <= 1'b0;
            counter_reg       <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= spmc_pkg::ST_OK;
            running_reg       <= 1'b0;
            direction_out_reg <= 1'b0;
            position_out_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            position_reg    <= position_next;
            destination_reg <= destination_next;
            direction_reg   <= direction_next;
            counter_reg     <= counter_next;
            out_valid_reg   <= out_valid_next;
            if (fire)
            begin
                status_reg        <= status_next;
                running_reg       <= (state_next == RS_MOVING);
                direction_out_reg <= direction_next;
                position_out_reg  <= spmc_pkg::FIELD_BITS'(position_next);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign running   = running_reg;
    assign direction = direction_out_reg;
    assign position  = position_out_reg;

endmodule

// ===== hdl/spmc_checker.sv =====
`include "step_position_move_controller_defines.svh"

module spmc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        running,
    input  logic        direction,
    input  logic [15:0] position
);

    logic [19:0] result_bits;

    assign result_bits = {status, running, direction, position};

    // A result that is not taken stays on the port unchanged.
    `SPMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits))

    // The input side only waits behind a result that is itself stalled.
    `SPMC_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

    // An axis that was never initialized cannot be running.
    `SPMC_ASSERT_SAME(a_noinit_idle, out_valid && (status == spmc_pkg::ST_NOINIT), !running)

endmodule

bind step_position_move_controller spmc_checker u_spmc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {
        AXIS_IDLE     = 2'd0,
        AXIS_MOVING   = 2'd1,
        AXIS_DISABLED = 2'd2
    } axis_state_t;

    typedef struct {
        logic [1:0]  status;
        logic        running;
        logic        direction;
        logic [15:0] position;
    } axis_result_t;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = spmc_pkg::OP_INIT;
    logic [15:0] target_location = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        running;
    logic        direction;
    logic [15:0] position;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = spmc_pkg::CFG_HOME;
    logic [15:0] cfg_data = 16'd0;

    step_position_move_controller dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .target_location (target_location),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .running         (running),
        .direction       (direction),
        .position        (position),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    spmc_pkg::item_t pending_cmds[$];
    axis_result_t    expected_results[$];
    spmc_pkg::item_t next_cmd;

    int send_idle_pct = 22;
    int recv_idle_pct = 71;
    int issued_items = 0;
    int accepted_items = 0;
    int checked_results = 0;
    int reg_writes = 0;
    int unit_steps = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int status_hits[4] = '{0, 0, 0, 0};

    // Expected axis state and register copies.
    axis_state_t ax_state = AXIS_DISABLED;
    logic [15:0] ax_pos = 16'd1000;
    logic [15:0] ax_dest = 16'd0;
    logic        ax_dir = 1'b0;
    logic [15:0] ax_count = 16'd0;
    logic [15:0] home_reg = 16'd1000;
    logic [15:0] max_reg = 16'd2000;
    logic [15:0] ppu_reg = 16'd400;

    task automatic predict_axis(input logic [1:0] op, input logic [15:0] tgt);
        axis_result_t res;
        logic [1:0]   st;
        st = spmc_pkg::ST_OK;
        case (op)
            spmc_pkg::OP_INIT:
            begin
                ax_pos = home_reg;
                ax_dest = home_reg;
                ax_dir = 1'b0;
                ax_state = AXIS_IDLE;
            end
            spmc_pkg::OP_MOVE:
            begin
                if (ax_state == AXIS_DISABLED)
                    st = spmc_pkg::ST_NOINIT;
                else if (tgt == ax_pos)
                    st = spmc_pkg::ST_SAME;
                else if (tgt > max_reg)
                    st = spmc_pkg::ST_RANGE;
                else
                begin
                    ax_dest = tgt;
                    ax_dir = (tgt > ax_pos);
                    ax_state = AXIS_MOVING;
                end
                status_hits[st]++;
            end
            spmc_pkg::OP_TICK:
            begin
                if (ax_state == AXIS_MOVING)
                begin
                    if (ax_count > ppu_reg)
                    begin
                        ax_pos = ax_dir ? ax_pos + 16'd1 : ax_pos - 16'd1;
                        if ((ax_dir && ax_pos >= ax_dest) || (!ax_dir && ax_pos <= ax_dest))
                            ax_state = AXIS_IDLE;
                        ax_count = 16'd0;
                        unit_steps++;
                    end
                    else
                        ax_count = ax_count + 16'd1;
                end
            end
            default:
            begin
            end
        endcase
        res.status = st;
        res.running = (ax_state == AXIS_MOVING);
        res.direction = ax_dir;
        res.position = ax_pos;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        axis_result_t want;
        logic         busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    spmc_pkg::CFG_HOME: home_reg = cfg_data;
                    spmc_pkg::CFG_MAX:  max_reg = cfg_data;
                    spmc_pkg::CFG_PPU:  ppu_reg = cfg_data;
                    default:
                    begin
                    end
                endcase
                reg_writes++;
                busy = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                predict_axis(opcode, target_location);
                accepted_items++;
                busy = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, status %0d position %0d",
                             $time, status, position);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("running", 16'(want.running), 16'(running));
                    check_field("direction", 16'(want.direction), 16'(direction));
                    check_field("position", want.position, position);
                    checked_results++;
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL step_position_move_controller");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!in_valid || accepted_items == issued_items)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    opcode <= next_cmd.opcode;
                    target_location <= next_cmd.target_location;
                    in_valid <= 1'b1;
                    issued_items++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void push_cmd(input logic [1:0] op, input logic [15:0] tgt);
        spmc_pkg::item_t it;
        it.opcode = op;
        it.target_location = tgt;
        pending_cmds.push_back(it);
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input spmc_pkg::cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] home, input logic [15:0] max_loc,
                            input logic [15:0] ppu);
        wait_drained();
        write_reg(spmc_pkg::CFG_HOME, home);
        write_reg(spmc_pkg::CFG_MAX, max_loc);
        write_reg(spmc_pkg::CFG_PPU, ppu);
    endtask

    // Mostly init, move and a random number of ticks, up to enough to arrive, with some noise mixed in.
    task automatic run_random_phase(input logic [15:0] home, input logic [15:0] max_loc,
                                    input logic [15:0] ppu, input int send_pct,
                                    input int recv_pct, input int n_items);
        int start;
        int span;
        int ticks;
        int spot;
        int k;
        set_regs(home, max_loc, ppu);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = pending_cmds.size() + issued_items;
        while (pending_cmds.size() + issued_items - start < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 4))
                    push_cmd(2'($urandom_range(3)), 16'($urandom));
            end
            else
            begin
                if ($urandom_range(99) < 80)
                    push_cmd(spmc_pkg::OP_INIT, 16'($urandom));
                span = $urandom_range(1, 8);
                spot = $urandom_range(1) ? int'(home) + span : int'(home) - span;
                spot = (spot < 0) ? 0 : ((spot > 65535) ? 65535 : spot);
                push_cmd(spmc_pkg::OP_MOVE, 16'(spot));
                ticks = $urandom_range(0, (int'(ppu) + 2) * span + 3);
                for (k = 0; k < ticks; k++)
                begin
                    if (k == ticks / 2 && $urandom_range(99) < 25)
                        push_cmd(spmc_pkg::OP_MOVE, 16'(int'(home) + $urandom_range(0, 6) - 3));
                    push_cmd(spmc_pkg::OP_TICK, 16'($urandom));
                end
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset register values.
        push_cmd(spmc_pkg::OP_MOVE, 16'd500);
        push_cmd(spmc_pkg::OP_TICK, 16'hFFFF);
        push_cmd(OP_UNUSED, 16'hFFFF);
        push_cmd(spmc_pkg::OP_INIT, 16'h0000);
        push_cmd(spmc_pkg::OP_MOVE, 16'd1000);
        push_cmd(spmc_pkg::OP_MOVE, 16'd2001);
        push_cmd(spmc_pkg::OP_MOVE, 16'hFFFF);
        push_cmd(spmc_pkg::OP_MOVE, 16'd2000);
        push_cmd(spmc_pkg::OP_TICK, 16'h0000);
        push_cmd(spmc_pkg::OP_TICK, 16'h0000);
        push_cmd(spmc_pkg::OP_TICK, 16'h0000);
        push_cmd(spmc_pkg::OP_MOVE, 16'd0);
        push_cmd(spmc_pkg::OP_TICK, 16'hA5A5);
        push_cmd(spmc_pkg::OP_INIT, 16'h0000);
        push_cmd(spmc_pkg::OP_TICK, 16'h5A5A);
        push_cmd(spmc_pkg::OP_MOVE, 16'd0);
        push_cmd(OP_UNUSED, 16'h5A5A);
        push_cmd(spmc_pkg::OP_INIT, 16'hFFFF);
        push_cmd(spmc_pkg::OP_MOVE, 16'd999);
        push_cmd(spmc_pkg::OP_INIT, 16'h0000);
        wait_drained();

        run_random_phase(16'd100, 16'd106, 16'd2, 22, 71, 560);
        run_random_phase(16'd0, 16'hFFFF, 16'd0, 71, 22, 560);
        run_random_phase(16'hFFFF, 16'hFFFF, 16'd1, 0, 0, 560);

        // Zero maximum: only a move to zero is in range.
        set_regs(16'd5, 16'd0, 16'd0);
        push_cmd(spmc_pkg::OP_INIT, 16'd0);
        push_cmd(spmc_pkg::OP_MOVE, 16'd0);
        repeat (12)
            push_cmd(spmc_pkg::OP_TICK, 16'd0);
        push_cmd(spmc_pkg::OP_MOVE, 16'd3);
        push_cmd(spmc_pkg::OP_MOVE, 16'd0);
        push_cmd(spmc_pkg::OP_MOVE, 16'd5);
        push_cmd(spmc_pkg::OP_INIT, 16'd0);

        // With the largest counter limit a short burst of ticks never steps the axis.
        set_regs(16'd5, 16'd0, 16'hFFFF);
        push_cmd(spmc_pkg::OP_INIT, 16'd0);
        push_cmd(spmc_pkg::OP_MOVE, 16'd0);
        repeat (8)
            push_cmd(spmc_pkg::OP_TICK, 16'd0);
        push_cmd(spmc_pkg::OP_INIT, 16'd0);
        wait_drained();
        repeat (4) @(posedge clk);

        if (expected_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        $display("Ran %0d items with %0d register writes; %0d results checked, %0d unit steps.",
                 accepted_items, reg_writes, checked_results, unit_steps);
        $display("Moves: %0d ok, %0d already there, %0d out of range, %0d before init.",
                 status_hits[spmc_pkg::ST_OK], status_hits[spmc_pkg::ST_SAME],
                 status_hits[spmc_pkg::ST_RANGE], status_hits[spmc_pkg::ST_NOINIT]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS step_position_move_controller");
        else
            $display("FAIL step_position_move_controller");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/spmc_pkg.sv
hdl/spmc_cfg_regs.sv
hdl/spmc_in_stage.sv
hdl/spmc_core.sv
hdl/step_position_move_controller.sv
hdl/spmc_checker.sv
tb/tb.sv
